@@ design/lcd4_pkg.sv @@
// Shared types, command codes and timing constants for the 4-bit character LCD controller.
`timescale 1ns / 1ps
`default_nettype none

package lcd4_pkg;

    // Defaults for the frame geometry of a 16x2 panel
    localparam int FRAME_CHARS_DEF = 32;
    localparam int ROW_CHARS_DEF   = 16;

    localparam int        TPM_W       = 16;
    localparam int        WAIT_W      = 22;
    localparam logic [TPM_W-1:0] TPM_RESET = 16'd1000;
    localparam int        INIT_WAIT_MS = 50;
    localparam int        INIT_STEPS   = 7;

    // Panel command bytes
    localparam logic [7:0] CMD_CLEAR       = 8'h01;
    localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
    localparam logic [7:0] CMD_DISPLAY_OFF = 8'h08;
    localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
    localparam logic [7:0] CMD_CURSOR_ON   = 8'h0F;
    localparam logic [7:0] CMD_FUNC_4BIT   = 8'h28;
    localparam logic [7:0] CMD_SET_ADDR    = 8'h80;
    localparam logic [7:0] CMD_ROW2        = 8'hC0;
    localparam logic [7:0] NIBBLE_WAKE     = 8'h20;

    // Phases of one byte on the bus
    localparam logic [2:0] PH_RS     = 3'd0;
    localparam logic [2:0] PH_HI_ON  = 3'd1;
    localparam logic [2:0] PH_HI_OFF = 3'd2;
    localparam logic [2:0] PH_LO_ON  = 3'd3;
    localparam logic [2:0] PH_LO_OFF = 3'd4;
    localparam logic [2:0] PH_HOLD   = 3'd5;

    typedef enum logic [2:0] {
        FN_TICK     = 3'd0,
        FN_CHAR     = 3'd1,
        FN_COMMIT   = 3'd2,
        FN_INIT     = 3'd3,
        FN_CUR_SHOW = 3'd4,
        FN_CUR_HIDE = 3'd5,
        FN_CUR_MOVE = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        JOB_IDLE   = 2'd0,
        JOB_INIT   = 2'd1,
        JOB_REDRAW = 2'd2,
        JOB_SINGLE = 2'd3
    } job_t;

    typedef enum logic [2:0] {
        K_END    = 3'd0,
        K_CMD    = 3'd1,
        K_DATA   = 3'd2,
        K_WAIT   = 3'd3,
        K_NIBBLE = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_CMP  = 2'd1,
        CS_EXEC = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic       rs;
        logic       en;
        logic [3:0] nib;
    } pin_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] b;
    } elem_t;

    typedef struct packed {
        logic load;
        logic cmp_step;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic commit_go;
        logic cmp_last;
    } ctrl_status_t;

    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = CMD_DISPLAY_OFF;
            3'd1:    r = CMD_FUNC_4BIT;
            3'd2:    r = CMD_CLEAR;
            3'd3:    r = CMD_ENTRY_MODE;
            3'd4:    r = CMD_DISPLAY_ON;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] first_phase(input kind_t k);
        return (k == K_NIBBLE) ? PH_HI_ON : PH_RS;
    endfunction

    function automatic logic [2:0] last_phase(input kind_t k);
        logic [2:0] r;
        case (k)
            K_CMD:    r = PH_HOLD;
            K_DATA:   r = PH_LO_OFF;
            K_NIBBLE: r = PH_HI_OFF;
            default:  r = PH_RS;
        endcase
        return r;
    endfunction

    // Pin levels after one phase of a bus element
    function automatic pin_t perform(input kind_t k, input logic [2:0] ph,
                                     input logic [7:0] b, input pin_t cur);
        pin_t r;
        r = cur;
        if (k != K_WAIT) begin
            case (ph)
                PH_RS:
                begin
                    r.rs = (k == K_DATA);
                end
                PH_HI_ON:
                begin
                    r.en  = 1'b1;
                    r.nib = b[7:4];
                end
                PH_LO_ON:
                begin
                    r.en  = 1'b1;
                    r.nib = b[3:0];
                end
                PH_HI_OFF, PH_LO_OFF:
                begin
                    r.en = 1'b0;
                end
                default:
                begin
                    r = cur;
                end
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/lcd4_ctrl.sv @@
// Sequencing FSM: takes a transaction, compares frames on an idle commit, executes, strobes done.
`timescale 1ns / 1ps
`default_nettype none

module lcd4_ctrl (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    input  lcd4_pkg::ctrl_status_t   st,
    output lcd4_pkg::ctrl_cmd_t      cmd,
    output logic                     busy,
    output logic                     done
);
    import lcd4_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (start) begin
                    state_next = st.commit_go ? CS_CMP : CS_EXEC;
                end
            end
            CS_CMP:
            begin
                if (st.cmp_last) begin
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC:
            begin
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.load     = (state_reg == CS_IDLE) && start;
        cmd.cmp_step = (state_reg == CS_CMP);
        cmd.exec     = (state_reg == CS_EXEC);
        busy         = (state_reg != CS_IDLE);
        done_next    = (state_reg == CS_EXEC);
        done         = done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= CS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    a_cmp_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_CMP) && !st.cmp_last |=> (state_reg == CS_CMP))
        else $error("compare sweep left early");

    a_plain_exec: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !st.commit_go |=> (state_reg == CS_EXEC))
        else $error("transaction did not go straight to execute");

    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobed in back-to-back cycles");

endmodule

`default_nettype wire

@@ design/lcd4_dp.sv @@
// Datapath: frame stores, compare sweep, bus sequencer registers and millisecond wait counter.
`timescale 1ns / 1ps
`default_nettype none

module lcd4_dp #(
    parameter int FRAME_CHARS = lcd4_pkg::FRAME_CHARS_DEF,
    parameter int ROW_CHARS   = lcd4_pkg::ROW_CHARS_DEF
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  lcd4_pkg::ctrl_cmd_t      cmd,
    output lcd4_pkg::ctrl_status_t   st,
    input  wire [2:0]                func,
    input  wire [4:0]                position,
    input  wire [7:0]                value,
    input  wire                      cfg_we,
    input  wire [15:0]               cfg_wdata,
    output logic                     rs_level,
    output logic                     enable_level,
    output logic [3:0]               bus_nibble,
    output logic                     busy_res,
    output logic                     rejected
);
    import lcd4_pkg::*;

    localparam int AW = $clog2(FRAME_CHARS);
    localparam int CW = $clog2(FRAME_CHARS + 1);
    localparam int SW = $clog2(FRAME_CHARS + 3);

    // Latched transaction
    logic [2:0] func_reg;
    logic [4:0] pos_reg;
    logic [7:0] val_reg;

    logic [TPM_W-1:0]  tpm_reg;
    pin_t              pins_reg, pins_next;
    job_t              job_reg, job_next;
    logic [SW-1:0]     step_reg, step_next;
    logic [2:0]        phase_reg, phase_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [7:0]        scmd_reg, scmd_next;
    logic              rej_reg, rej_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              diff_reg, diff_next;

    // Frame stores
    logic [7:0]             pend_mem [FRAME_CHARS];
    logic [7:0]             shown_mem [FRAME_CHARS];
    logic [FRAME_CHARS-1:0] pend_valid;
    logic [FRAME_CHARS-1:0] shown_valid;
    logic [7:0]             pend_q, shown_q;
    logic                   pend_vq, shown_vq;
    logic [7:0]             pend_d, shown_d;
    logic [AW-1:0]          cmp_raddr, shown_raddr, redraw_idx;
    logic signed [SW+1:0]   rdr_k;

    logic          pend_we, shown_we, shown_clear;
    logic [AW-1:0] pend_waddr, shown_waddr;
    logic [7:0]    shown_wdata;

    logic              job_busy, start_job, do_advance;
    job_t              new_job, ent_job;
    logic [7:0]        new_cmd;
    logic [SW-1:0]     ent_step;
    logic [2:0]        ent_ph, phase_inc;
    logic [WAIT_W-1:0] wait_dec;
    elem_t             cur, ent;

    function automatic elem_t elem_at(input job_t j, input logic [SW-1:0] s,
                                      input logic [7:0] scmd, input logic [7:0] mb);
        elem_t e;
        int    k;
        e.kind = K_END;
        e.b    = 8'h00;
        k      = int'(s) - 1;
        case (j)
            JOB_INIT:
            begin
                if (s == '0) begin
                    e.kind = K_WAIT;
                end else if (int'(s) == 1) begin
                    e.kind = K_NIBBLE;
                    e.b    = NIBBLE_WAKE;
                end else if (int'(s) < INIT_STEPS) begin
                    e.kind = K_CMD;
                    e.b    = init_cmd(3'(int'(s) - 2));
                end
            end
            JOB_SINGLE:
            begin
                if (s == '0) begin
                    e.kind = K_CMD;
                    e.b    = scmd;
                end
            end
            JOB_REDRAW:
            begin
                if (s == '0) begin
                    e.kind = K_CMD;
                    e.b    = CMD_CLEAR;
                end else if (ROW_CHARS < FRAME_CHARS && k == ROW_CHARS) begin
                    e.kind = K_CMD;
                    e.b    = CMD_ROW2;
                end else begin
                    if (ROW_CHARS < FRAME_CHARS && k > ROW_CHARS) begin
                        k = k - 1;
                    end
                    if (k < FRAME_CHARS) begin
                        e.kind = K_DATA;
                        e.b    = mb;
                    end
                end
            end
            default:
            begin
                e.kind = K_END;
            end
        endcase
        return e;
    endfunction

    function automatic logic [WAIT_W-1:0] wait_for(input kind_t k, input logic [TPM_W-1:0] t);
        logic [WAIT_W-1:0] r;
        if (k == K_WAIT) begin
            r = WAIT_W'(t) * WAIT_W'(INIT_WAIT_MS);
        end else begin
            r = WAIT_W'(t);
        end
        return r;
    endfunction

    // Character index of the redraw data element at the current step
    always_comb
    begin
        rdr_k = (SW + 2)'($signed({2'b00, step_reg}) - 1);
        if (ROW_CHARS < FRAME_CHARS && rdr_k > (SW + 2)'(ROW_CHARS)) begin
            rdr_k = (SW + 2)'(rdr_k - 1);
        end
        if (rdr_k >= 0 && rdr_k < (SW + 2)'(FRAME_CHARS)) begin
            redraw_idx = AW'(rdr_k);
        end else begin
            redraw_idx = '0;
        end
    end

    assign cmp_raddr   = (cnt_reg < CW'(FRAME_CHARS)) ? AW'(cnt_reg) : '0;
    assign shown_raddr = cmd.cmp_step ? cmp_raddr : redraw_idx;
    assign pend_d      = pend_q & {8{pend_vq}};
    assign shown_d     = shown_q & {8{shown_vq}};

    assign job_busy     = (job_reg != JOB_IDLE);
    assign st.commit_go = (func == FN_COMMIT) && !job_busy;
    assign st.cmp_last  = (cnt_reg == CW'(FRAME_CHARS));

    // Compare sweep: read entry n, compare and copy it in the cycle after
    always_comb
    begin
        cnt_next    = cnt_reg;
        diff_next   = diff_reg;
        shown_we    = 1'b0;
        shown_waddr = AW'(cnt_reg - CW'(1));
        shown_wdata = pend_d;
        if (cmd.load) begin
            cnt_next  = '0;
            diff_next = 1'b0;
        end else if (cmd.cmp_step) begin
            if (cnt_reg != '0) begin
                shown_we = 1'b1;
                if (pend_d != shown_d) begin
                    diff_next = 1'b1;
                end
            end
            if (!st.cmp_last) begin
                cnt_next = cnt_reg + CW'(1);
            end
        end
    end

    assign pend_we     = cmd.exec && (func_reg == FN_CHAR) && (32'(pos_reg) < FRAME_CHARS);
    assign pend_waddr  = AW'(pos_reg);
    assign shown_clear = cmd.exec && (func_reg == FN_INIT) && !job_busy;

    assign wait_dec  = (wait_reg != '0) ? wait_reg - WAIT_W'(1) : '0;
    assign phase_inc = phase_reg + 3'd1;
    assign cur       = elem_at(job_reg, step_reg, scmd_reg, shown_d);

    always_comb
    begin
        start_job  = 1'b0;
        do_advance = 1'b0;
        new_job    = JOB_IDLE;
        new_cmd    = scmd_reg;
        rej_next   = rej_reg;
        pins_next  = pins_reg;
        job_next   = job_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        wait_next  = wait_reg;
        scmd_next  = scmd_reg;

        if (cmd.exec) begin
            rej_next = 1'b0;
            case (func_reg)
                FN_TICK:
                begin
                    if (job_busy) begin
                        wait_next = wait_dec;
                        if (wait_dec == '0) begin
                            if (cur.kind != K_END && phase_reg < last_phase(cur.kind)) begin
                                phase_next = phase_inc;
                                pins_next  = perform(cur.kind, phase_inc, cur.b, pins_reg);
                                wait_next  = wait_for(cur.kind, tpm_reg);
                            end else begin
                                do_advance = 1'b1;
                            end
                        end
                    end
                end
                FN_COMMIT:
                begin
                    if (job_busy) begin
                        rej_next = 1'b1;
                    end else if (diff_reg) begin
                        start_job = 1'b1;
                        new_job   = JOB_REDRAW;
                    end
                end
                FN_INIT:
                begin
                    if (job_busy) begin
                        rej_next = 1'b1;
                    end else begin
                        start_job = 1'b1;
                        new_job   = JOB_INIT;
                    end
                end
                FN_CUR_SHOW, FN_CUR_HIDE, FN_CUR_MOVE:
                begin
                    if (job_busy) begin
                        rej_next = 1'b1;
                    end else begin
                        start_job = 1'b1;
                        new_job   = JOB_SINGLE;
                        if (func_reg == FN_CUR_SHOW) begin
                            new_cmd = CMD_CURSOR_ON;
                        end else if (func_reg == FN_CUR_HIDE) begin
                            new_cmd = CMD_DISPLAY_ON;
                        end else begin
                            new_cmd = CMD_SET_ADDR + val_reg;
                        end
                    end
                end
                default:
                begin
                    rej_next = 1'b0;
                end
            endcase
        end

        if (start_job || do_advance) begin
            job_next  = ent_job;
            step_next = ent_step;
            scmd_next = new_cmd;
            if (ent.kind == K_END) begin
                job_next   = JOB_IDLE;
                step_next  = '0;
                phase_next = PH_RS;
                wait_next  = '0;
            end else begin
                phase_next = ent_ph;
                pins_next  = perform(ent.kind, ent_ph, ent.b, pins_reg);
                wait_next  = wait_for(ent.kind, tpm_reg);
            end
        end
    end

    // Element entered on a job start or on stepping past the last phase
    assign ent_job  = start_job ? new_job : job_reg;
    assign ent_step = start_job ? '0 : step_reg + SW'(1);
    assign ent      = elem_at(ent_job, ent_step, new_cmd, 8'h00);
    assign ent_ph   = first_phase(ent.kind);

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            func_reg <= func;
            pos_reg  <= position;
            val_reg  <= value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_we) begin
            pend_mem[pend_waddr] <= val_reg;
        end
        pend_q <= pend_mem[cmp_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (shown_we) begin
            shown_mem[shown_waddr] <= shown_wdata;
        end
        shown_q <= shown_mem[shown_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_valid  <= '0;
            shown_valid <= '0;
            pend_vq     <= 1'b0;
            shown_vq    <= 1'b0;
        end else begin
            if (pend_we) begin
                pend_valid[pend_waddr] <= 1'b1;
            end
            if (shown_clear) begin
                shown_valid <= '0;
            end else if (shown_we) begin
                shown_valid[shown_waddr] <= 1'b1;
            end
            pend_vq  <= pend_valid[cmp_raddr];
            shown_vq <= shown_valid[shown_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tpm_reg   <= TPM_RESET;
            pins_reg  <= '0;
            job_reg   <= JOB_IDLE;
            step_reg  <= '0;
            phase_reg <= PH_RS;
            wait_reg  <= '0;
            scmd_reg  <= '0;
            rej_reg   <= 1'b0;
            cnt_reg   <= '0;
            diff_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                // a zero rate would stall forever; treat it as one
                tpm_reg <= (cfg_wdata == '0) ? TPM_W'(1) : cfg_wdata;
            end
            pins_reg  <= pins_next;
            job_reg   <= job_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
            wait_reg  <= wait_next;
            scmd_reg  <= scmd_next;
            rej_reg   <= rej_next;
            cnt_reg   <= cnt_next;
            diff_reg  <= diff_next;
        end
    end

    assign rs_level     = pins_reg.rs;
    assign enable_level = pins_reg.en;
    assign bus_nibble   = pins_reg.nib;
    assign busy_res     = job_busy;
    assign rejected     = rej_reg;

    a_en_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        pins_reg.en |-> job_busy)
        else $error("enable high with no job running");

    a_wait_live: assert property (@(posedge clk) disable iff (!rst_n)
        job_busy |-> (wait_reg != '0))
        else $error("job running with an empty wait counter");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !job_busy |-> (step_reg == '0) && (phase_reg == PH_RS))
        else $error("idle sequencer left step or phase set");

    a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && rej_next |=> (job_reg == $past(job_reg)) && $stable(pins_reg))
        else $error("rejected transaction changed the sequencer");

endmodule

`default_nettype wire

@@ design/char_lcd_4bit_refresh_controller.sv @@
// Top level of the 4-bit character LCD controller: state machine plus datapath.
//
// Usage:
//   Drive func/position/value and pulse start; a transaction is taken on a
//   rising edge with start high and busy low. Every transaction gives one
//   result: done is high for exactly one cycle with rs_level, enable_level,
//   bus_nibble, busy_res and rejected valid. The receiver cannot stall.
// Sequencing:
//   Every transaction passes through the execute state and the done register,
//   with a new one accepted in the done cycle. A commit that is not rejected
//   first walks the FRAME_CHARS stored characters through the read ports of
//   both frame stores, one per cycle, before it executes.
// Timing on the panel side is counted in tick transactions: each pin change
//   waits ticks_per_ms ticks per millisecond; the init sequence waits 50 ms first.
// Configuration: cfg_we with cfg_wdata writes ticks_per_ms (zero reads as
//   one); write it only while no transaction is in flight.
// Reset: asynchronous rst_n clears pins, job state and both frames
//   (ticks_per_ms returns to 1000); no clearing sweep is needed.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_4bit_refresh_controller #(
    parameter int FRAME_CHARS = lcd4_pkg::FRAME_CHARS_DEF,
    parameter int ROW_CHARS   = lcd4_pkg::ROW_CHARS_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    output logic       busy,
    input  wire [2:0]  func,
    input  wire [4:0]  position,
    input  wire [7:0]  value,
    input  wire        cfg_we,
    input  wire [15:0] cfg_wdata,
    output logic       done,
    output logic       rs_level,
    output logic       enable_level,
    output logic [3:0] bus_nibble,
    output logic       busy_res,
    output logic       rejected
);
    import lcd4_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t st;

    lcd4_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    lcd4_dp #(
        .FRAME_CHARS (FRAME_CHARS),
        .ROW_CHARS   (ROW_CHARS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .func         (func),
        .position     (position),
        .value        (value),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .rs_level     (rs_level),
        .enable_level (enable_level),
        .bus_nibble   (bus_nibble),
        .busy_res     (busy_res),
        .rejected     (rejected)
    );

endmodule

`default_nettype wire

@@ test/char_lcd_4bit_refresh_controller_tb.sv @@
// Self-checking testbench for the 4-bit character LCD refresh controller.
`timescale 1ns / 1ps

module char_lcd_4bit_refresh_controller_tb;

    import lcd4_pkg::*;

    localparam int          FRAME     = FRAME_CHARS_DEF;
    localparam int          ROWS      = ROW_CHARS_DEF;
    localparam logic [2:0]  FN_UNUSED = 3'd7;
    localparam logic [39:0] BOOT_CMDS = {CMD_DISPLAY_OFF, CMD_FUNC_4BIT, CMD_CLEAR,
                                         CMD_ENTRY_MODE, CMD_DISPLAY_ON};

    typedef struct packed {
        logic       rs;
        logic       en;
        logic [3:0] nib;
        logic       busy_flag;
        logic       rej;
    } lcd_result_t;

    typedef struct packed {
        bit          pre_cfg;
        logic [15:0] cfg_val;
        logic [2:0]  fn;
        logic [4:0]  pos;
        logic [7:0]  val;
        bit          typed;
        lcd_result_t want;
    } dir_row_t;

    localparam lcd_result_t PIN_IDLE   = {1'b0, 1'b0, 4'h0, 1'b0, 1'b0};
    localparam lcd_result_t BUSY_START = {1'b0, 1'b0, 4'h0, 1'b1, 1'b0};
    localparam lcd_result_t BUSY_REJ   = {1'b0, 1'b0, 4'h0, 1'b1, 1'b1};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  func = '0;
    logic [4:0]  position = '0;
    logic [7:0]  value = '0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    wire         busy;
    wire         done;
    wire         rs_level;
    wire         enable_level;
    wire  [3:0]  bus_nibble;
    wire         busy_res;
    wire         rejected;

    // Predicted display state
    logic [7:0]  disp_shown [FRAME];
    logic [7:0]  disp_pending [FRAME];
    logic        pin_rs, pin_en;
    logic [3:0]  pin_nib;
    job_t        job_q;
    int unsigned elem_idx;
    logic [2:0]  elem_ph;
    int unsigned tick_left;
    logic [7:0]  single_byte;
    int unsigned tpm;

    lcd_result_t pin_expect_q [$];
    dir_row_t    dir_tab [$];
    int          mismatch_cnt = 0;
    int          sent_cnt = 0;
    bit          burst_mode = 1'b0;

    char_lcd_4bit_refresh_controller u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .position     (position),
        .value        (value),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .rs_level     (rs_level),
        .enable_level (enable_level),
        .bus_nibble   (bus_nibble),
        .busy_res     (busy_res),
        .rejected     (rejected)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("char_lcd_4bit_refresh_controller verification failed");
        $finish;
    end

    // Bus element number s of the running job; b carries its byte
    function automatic kind_t elem_kind(input int unsigned s, output logic [7:0] b);
        kind_t k;
        k = K_END;
        b = '0;
        case (job_q)
            JOB_INIT:
            begin
                if (s == 0) begin
                    k = K_WAIT;
                end else if (s == 1) begin
                    k = K_NIBBLE;
                    b = NIBBLE_WAKE;
                end else if (s < 7) begin
                    k = K_CMD;
                    b = BOOT_CMDS[8 * (6 - s) +: 8];
                end
            end
            JOB_SINGLE:
            begin
                if (s == 0) begin
                    k = K_CMD;
                    b = single_byte;
                end
            end
            JOB_REDRAW:
            begin
                if (s == 0) begin
                    k = K_CMD;
                    b = CMD_CLEAR;
                end else if (s == ROWS + 1) begin
                    k = K_CMD;
                    b = CMD_ROW2;
                end else if (s <= ROWS) begin
                    k = K_DATA;
                    b = disp_shown[s - 1];
                end else if (s <= FRAME + 1) begin
                    k = K_DATA;
                    b = disp_shown[s - 2];
                end
            end
            default:
            begin
            end
        endcase
        return k;
    endfunction

    // Set the pins for the current phase and arm the tick countdown
    function automatic void drive_pins(input kind_t k, input logic [7:0] b);
        int unsigned ms;
        ms = (k == K_WAIT) ? INIT_WAIT_MS : 1;
        if (k != K_WAIT) begin
            case (elem_ph)
                PH_RS:
                begin
                    pin_rs = (k == K_DATA);
                end
                PH_HI_ON:
                begin
                    pin_en  = 1'b1;
                    pin_nib = b[7:4];
                end
                PH_LO_ON:
                begin
                    pin_en  = 1'b1;
                    pin_nib = b[3:0];
                end
                PH_HI_OFF, PH_LO_OFF:
                begin
                    pin_en = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        tick_left = (ms * tpm) & 32'h003F_FFFF;
        if (tick_left == 0) tick_left = 1;
    endfunction

    function automatic void enter_elem();
        logic [7:0] b;
        kind_t      k;
        k = elem_kind(elem_idx, b);
        if (k == K_END) begin
            job_q     = JOB_IDLE;
            elem_idx  = 0;
            elem_ph   = PH_RS;
            tick_left = 0;
        end else begin
            elem_ph = (k == K_NIBBLE) ? PH_HI_ON : PH_RS;
            drive_pins(k, b);
        end
    endfunction

    function automatic void next_action();
        logic [7:0] b;
        kind_t      k;
        logic [2:0] last;
        k = elem_kind(elem_idx, b);
        last = (k == K_CMD) ? PH_HOLD : (k == K_DATA) ? PH_LO_OFF :
               (k == K_NIBBLE) ? PH_HI_OFF : PH_RS;
        if (k != K_END && elem_ph < last) begin
            elem_ph = elem_ph + 3'd1;
            drive_pins(k, b);
        end else begin
            elem_idx++;
            enter_elem();
        end
    endfunction

    function automatic void launch(input job_t j);
        job_q    = j;
        elem_idx = 0;
        enter_elem();
    endfunction

    function automatic lcd_result_t lcd_predict(input logic [2:0] f, input logic [4:0] p,
                                                input logic [7:0] v);
        lcd_result_t r;
        bit          was_busy;
        bit          diff;
        r = PIN_IDLE;
        was_busy = (job_q != JOB_IDLE);
        diff = 1'b0;
        case (f)
            FN_TICK:
            begin
                if (was_busy) begin
                    if (tick_left > 0) tick_left--;
                    if (tick_left == 0) next_action();
                end
            end
            FN_CHAR:
            begin
                disp_pending[p] = v;
            end
            FN_COMMIT, FN_INIT, FN_CUR_SHOW, FN_CUR_HIDE, FN_CUR_MOVE:
            begin
                if (was_busy) begin
                    r.rej = 1'b1;
                end else if (f == FN_COMMIT) begin
                    for (int i = 0; i < FRAME; i++) begin
                        if (disp_pending[i] != disp_shown[i]) diff = 1'b1;
                        disp_shown[i] = disp_pending[i];
                    end
                    if (diff) launch(JOB_REDRAW);
                end else if (f == FN_INIT) begin
                    for (int i = 0; i < FRAME; i++) disp_shown[i] = '0;
                    launch(JOB_INIT);
                end else begin
                    if (f == FN_CUR_SHOW) single_byte = CMD_CURSOR_ON;
                    else if (f == FN_CUR_HIDE) single_byte = CMD_DISPLAY_ON;
                    else single_byte = CMD_SET_ADDR + v;
                    launch(JOB_SINGLE);
                end
            end
            default:
            begin
            end
        endcase
        r.rs        = pin_rs;
        r.en        = pin_en;
        r.nib       = pin_nib;
        r.busy_flag = (job_q != JOB_IDLE);
        return r;
    endfunction

    // Present one transaction after a random gap, none in burst mode, and hold it until accepted
    task automatic lcd_send(input logic [2:0] f, input logic [4:0] p, input logic [7:0] v,
                            input bit typed, input lcd_result_t want);
        int          gap;
        lcd_result_t r;
        gap = burst_mode ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        func     <= f;
        position <= p;
        value    <= v;
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        r = lcd_predict(f, p, v);
        pin_expect_q.push_back(typed ? want : r);
        sent_cnt++;
    endtask

    task automatic lcd_set_tpm(input logic [15:0] v);
        start <= 1'b0;
        while (pin_expect_q.size() != 0) @(posedge clk);
        repeat (FRAME + 8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tpm = (v == 16'd0) ? 32'd1 : 32'(v);
    endtask

    // Tick the running job to its end, with char writes and refused or unused commands mixed in
    task automatic lcd_run_job();
        int r;
        while (job_q != JOB_IDLE) begin
            r = $urandom_range(0, 99);
            if (r < 85)
                lcd_send(FN_TICK, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                         1'b0, PIN_IDLE);
            else if (r < 93)
                lcd_send(FN_CHAR, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                         1'b0, PIN_IDLE);
            else
                lcd_send(3'($urandom_range(FN_COMMIT, FN_UNUSED)),
                         5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                         1'b0, PIN_IDLE);
        end
    endtask

    task automatic lcd_random_phase(input int target);
        int stop_at;
        int r;
        int n;
        stop_at = sent_cnt + target;
        while (sent_cnt < stop_at) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 35) begin
                n = $urandom_range(1, 6);
                repeat (n)
                    lcd_send(FN_CHAR, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                             1'b0, PIN_IDLE);
                lcd_send(FN_COMMIT, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                         1'b0, PIN_IDLE);
            end else if (r < 50) begin
                lcd_send(FN_INIT, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                         1'b0, PIN_IDLE);
            end else if (r < 75) begin
                case ($urandom_range(0, 2))
                    0: lcd_send(FN_CUR_SHOW, 5'($urandom_range(0, 31)),
                                8'($urandom_range(0, 255)), 1'b0, PIN_IDLE);
                    1: lcd_send(FN_CUR_HIDE, 5'($urandom_range(0, 31)),
                                8'($urandom_range(0, 255)), 1'b0, PIN_IDLE);
                    default: lcd_send(FN_CUR_MOVE, 5'($urandom_range(0, 31)),
                                      8'($urandom_range(0, 255)), 1'b0, PIN_IDLE);
                endcase
            end else begin
                n = $urandom_range(1, 5);
                repeat (n)
                    lcd_send(3'($urandom_range(FN_TICK, FN_UNUSED)), 5'($urandom_range(0, 31)),
                             8'($urandom_range(0, 255)), 1'b0, PIN_IDLE);
            end
            lcd_run_job();
        end
    endtask

    function automatic dir_row_t mk_row(input bit pre_cfg, input logic [15:0] cfg_val,
                                        input logic [2:0] fn, input logic [4:0] pos,
                                        input logic [7:0] val, input bit typed,
                                        input lcd_result_t want);
        dir_row_t row;
        row = {pre_cfg, cfg_val, fn, pos, val, typed, want};
        return row;
    endfunction

    always @(posedge clk)
    begin
        lcd_result_t exp_r;
        if (rst_n === 1'b1 && done === 1'b1) begin
            if (pin_expect_q.size() == 0) begin
                $error("unexpected result: no transaction outstanding");
                mismatch_cnt++;
            end else begin
                exp_r = pin_expect_q.pop_front();
                if (rs_level !== exp_r.rs) begin
                    $error("rs_level: expected %0d, got %0d", exp_r.rs, rs_level);
                    mismatch_cnt++;
                end
                if (enable_level !== exp_r.en) begin
                    $error("enable_level: expected %0d, got %0d", exp_r.en, enable_level);
                    mismatch_cnt++;
                end
                if (bus_nibble !== exp_r.nib) begin
                    $error("bus_nibble: expected %0h, got %0h", exp_r.nib, bus_nibble);
                    mismatch_cnt++;
                end
                if (busy_res !== exp_r.busy_flag) begin
                    $error("busy_res: expected %0d, got %0d", exp_r.busy_flag, busy_res);
                    mismatch_cnt++;
                end
                if (rejected !== exp_r.rej) begin
                    $error("rejected: expected %0d, got %0d", exp_r.rej, rejected);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial
    begin
        int r;
        tpm         = 32'(TPM_RESET);
        pin_rs      = 1'b0;
        pin_en      = 1'b0;
        pin_nib     = '0;
        job_q       = JOB_IDLE;
        elem_idx    = 0;
        elem_ph     = PH_RS;
        tick_left   = 0;
        single_byte = '0;
        for (int i = 0; i < FRAME; i++) begin
            disp_shown[i]   = '0;
            disp_pending[i] = '0;
        end

        // Idle behavior at the reset tick rate, then single commands at one tick per ms
        dir_tab.push_back(mk_row(1'b0, 16'd0, FN_TICK, 5'd0, 8'h00, 1'b1, PIN_IDLE));
        dir_tab.push_back(mk_row(1'b0, 16'd0, FN_UNUSED, 5'd31, 8'hFF, 1'b1, PIN_IDLE));
        dir_tab.push_back(mk_row(1'b0, 16'd0, FN_COMMIT, 5'd0, 8'h00, 1'b1, PIN_IDLE));
        dir_tab.push_back(mk_row(1'b0, 16'd0, FN_CHAR, 5'd0, 8'hFF, 1'b1, PIN_IDLE));
        dir_tab.push_back(mk_row(1'b0, 16'd0, FN_CHAR, 5'd31, 8'h00, 1'b1, PIN_IDLE));
        dir_tab.push_back(mk_row(1'b1, 16'd0, FN_CUR_MOVE, 5'd0, 8'hFF, 1'b1, BUSY_START));
        dir_tab.push_back(mk_row(1'b0, 16'd0, FN_INIT, 5'd0, 8'h00, 1'b1, BUSY_REJ));
        repeat (6)
            dir_tab.push_back(mk_row(1'b0, 16'd0, FN_TICK, 5'd0, 8'h00, 1'b0, PIN_IDLE));
        dir_tab.push_back(mk_row(1'b0, 16'd0, FN_CUR_SHOW, 5'd0, 8'h00, 1'b0, PIN_IDLE));
        dir_tab.push_back(mk_row(1'b0, 16'd0, FN_COMMIT, 5'd0, 8'h00, 1'b0, PIN_IDLE));
        dir_tab.push_back(mk_row(1'b0, 16'd0, FN_CUR_HIDE, 5'd7, 8'h55, 1'b0, PIN_IDLE));
        dir_tab.push_back(mk_row(1'b0, 16'd0, FN_UNUSED, 5'd0, 8'h00, 1'b0, PIN_IDLE));
        dir_tab.push_back(mk_row(1'b0, 16'd0, FN_CHAR, 5'd17, 8'h80, 1'b0, PIN_IDLE));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].pre_cfg) lcd_set_tpm(dir_tab[i].cfg_val);
            lcd_send(dir_tab[i].fn, dir_tab[i].pos, dir_tab[i].val, dir_tab[i].typed,
                     dir_tab[i].want);
        end
        lcd_run_job();

        lcd_random_phase(500);
        lcd_set_tpm(16'd2);
        lcd_random_phase(250);
        lcd_set_tpm(16'd1);
        lcd_random_phase(250);

        // Slowest tick rate: start a job and poke it without waiting it out
        lcd_set_tpm(16'hFFFF);
        burst_mode = 1'b0;
        lcd_send(FN_CHAR, 5'd31, 8'hFF, 1'b0, PIN_IDLE);
        lcd_send(FN_COMMIT, 5'd0, 8'h00, 1'b0, PIN_IDLE);
        lcd_send(FN_CUR_MOVE, 5'd0, 8'h00, 1'b0, PIN_IDLE);
        repeat (60) begin
            r = $urandom_range(0, 99);
            if (r < 80)
                lcd_send(FN_TICK, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                         1'b0, PIN_IDLE);
            else
                lcd_send(3'($urandom_range(FN_CHAR, FN_UNUSED)), 5'($urandom_range(0, 31)),
                         8'($urandom_range(0, 255)), 1'b0, PIN_IDLE);
        end

        start <= 1'b0;
        while (pin_expect_q.size() != 0) @(posedge clk);
        repeat (FRAME + 16) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("char_lcd_4bit_refresh_controller verification clean");
        else
            $display("char_lcd_4bit_refresh_controller verification failed");
        $finish;
    end

endmodule
